@@ hdl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg
// Types, constants and arithmetic helpers shared by the bounce trajectory
// stepper: payload structs, register indexes and the divide-by-20 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

  localparam int CoordW    = 16;
  localparam int StepW     = 10;
  localparam int NumPoints = 800;
  localparam logic [StepW-1:0] LastStep = StepW'(NumPoints - 1);

  // 37 * bound needs 22 bits; 37 * bound - 17 * (pos + vel) needs 23 bits.
  localparam int Bound37W = 22;
  localparam int NumW     = 23;
  localparam int SumW     = CoordW + 1;
  localparam int PreSatW  = 19;

  // ceil(2^24 / 5): exact reciprocal for 21-bit dividends.
  localparam int RecipShift = 24;
  localparam int QuarterW   = NumW - 2;
  localparam int RecipW     = 22;
  localparam int ProdW      = QuarterW + RecipW;
  localparam logic [RecipW-1:0] RecipFive = 22'd3355444;

  typedef enum logic {
    FuncStart   = 1'b0,
    FuncAdvance = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    RegMinX = 2'd0,
    RegMinY = 2'd1,
    RegMaxX = 2'd2,
    RegMaxY = 2'd3
  } cfg_reg_t;

  typedef logic signed [CoordW-1:0]   coord_t;
  typedef logic signed [Bound37W-1:0] bound37_t;

  typedef struct packed {
    func_t  func;
    coord_t past_x;
    coord_t past_y;
    coord_t now_x;
    coord_t now_y;
  } in_item_t;

  typedef struct packed {
    coord_t           point_x;
    coord_t           point_y;
    logic [StepW-1:0] step_number;
    logic             final_point;
  } out_item_t;

  typedef struct packed {
    coord_t   min_x;
    coord_t   min_y;
    coord_t   max_x;
    coord_t   max_y;
    bound37_t min_x37;
    bound37_t min_y37;
    bound37_t max_x37;
    bound37_t max_y37;
  } bounds_t;

  function automatic bound37_t times37(input coord_t b);
    bound37_t w;
    w = Bound37W'(b);
    return (w <<< 5) + (w <<< 2) + w;
  endfunction

  // Signed division by 20, truncated toward zero: |a| / 4 then times 1/5.
  function automatic logic signed [NumW-1:0] div20(input logic signed [NumW-1:0] a);
    logic [NumW-1:0]     mag;
    logic [QuarterW-1:0] quarter;
    logic [ProdW-1:0]    prod;
    logic [NumW-1:0]     q;
    mag     = a[NumW-1] ? $unsigned(-a) : $unsigned(a);
    quarter = mag[NumW-1:2];
    prod    = ProdW'(quarter) * ProdW'(RecipFive);
    q       = NumW'(prod[ProdW-1:RecipShift]);
    return a[NumW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic coord_t sat_coord(input logic signed [PreSatW-1:0] v);
    coord_t r;
    if (v > PreSatW'(signed'(32'sd32767))) begin
      r = 16'sh7FFF;
    end else if (v < PreSatW'(signed'(-32'sd32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bts_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bts_cfg_regs
// Box wall registers with their 37x multiples kept alongside, so the
// reflection path only needs a subtract from a stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_data,
  output bts_pkg::bounds_t     bounds
);
  import bts_pkg::*;

  bounds_t bounds_r;
  bounds_t bounds_nxt;

  assign cfg_ready = 1'b1;
  assign bounds    = bounds_r;

  always_comb begin
    bounds_nxt = bounds_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        RegMinX: begin
          bounds_nxt.min_x   = coord_t'(cfg_data);
          bounds_nxt.min_x37 = times37(coord_t'(cfg_data));
        end
        RegMinY: begin
          bounds_nxt.min_y   = coord_t'(cfg_data);
          bounds_nxt.min_y37 = times37(coord_t'(cfg_data));
        end
        RegMaxX: begin
          bounds_nxt.max_x   = coord_t'(cfg_data);
          bounds_nxt.max_x37 = times37(coord_t'(cfg_data));
        end
        RegMaxY: begin
          bounds_nxt.max_y   = coord_t'(cfg_data);
          bounds_nxt.max_y37 = times37(coord_t'(cfg_data));
        end
        default: bounds_nxt = bounds_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.min_x   <= 16'sd0;
      bounds_r.min_y   <= 16'sd0;
      bounds_r.max_x   <= 16'sd100;
      bounds_r.max_y   <= 16'sd100;
      bounds_r.min_x37 <= 22'sd0;
      bounds_r.min_y37 <= 22'sd0;
      bounds_r.max_x37 <= 22'sd3700;
      bounds_r.max_y37 <= 22'sd3700;
    end else begin
      bounds_r <= bounds_nxt;
    end
  end

  bounds_min_x37_ok: assert property (@(posedge clk) disable iff (!rst_n)
    bounds_r.min_x37 == times37(bounds_r.min_x))
    else $error("min_x multiple out of step with min_x");
  bounds_max_y37_ok: assert property (@(posedge clk) disable iff (!rst_n)
    bounds_r.max_y37 == times37(bounds_r.max_y))
    else $error("max_y multiple out of step with max_y");
  cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_reg_t'(cfg_index) == RegMaxX |=> bounds_r.max_x == $past(cfg_data))
    else $error("max_x write lost");

endmodule

`default_nettype wire

@@ hdl/bts_axis_step.sv @@
// ----------------------------------------------------------------------------
// bts_axis_step
// One axis of an advance: add velocity, test against the walls, reflect with
// 17/20 restitution and saturate the position.
// ----------------------------------------------------------------------------
`default_nettype none

module bts_axis_step (
  input  wire bts_pkg::coord_t   pos,
  input  wire bts_pkg::coord_t   vel,
  input  wire bts_pkg::coord_t   lo,
  input  wire bts_pkg::coord_t   hi,
  input  wire bts_pkg::bound37_t lo37,
  input  wire bts_pkg::bound37_t hi37,
  output bts_pkg::coord_t        pos_nxt,
  output bts_pkg::coord_t        vel_nxt
);
  import bts_pkg::*;

  logic signed [SumW-1:0]    sum;
  logic signed [SumW-1:0]    lo_ext;
  logic signed [SumW-1:0]    hi_ext;
  logic                      below;
  logic                      above;
  logic                      reflect;
  logic signed [NumW-1:0]    sum_w;
  logic signed [NumW-1:0]    vel_w;
  logic signed [NumW-1:0]    num;
  logic signed [NumW-1:0]    refl;
  logic signed [NumW-1:0]    vel_refl;
  logic signed [PreSatW-1:0] pos_pre;

  always_comb begin
    sum    = SumW'(pos) + SumW'(vel);
    lo_ext = SumW'(lo);
    hi_ext = SumW'(hi);
    below  = sum < lo_ext;
    // An inverted box tests the low wall first and only then the high wall.
    above  = !below && (sum > hi_ext);
    reflect = below || above;

    sum_w    = NumW'(sum);
    num      = NumW'(below ? lo37 : hi37) - ((sum_w <<< 4) + sum_w);
    refl     = div20(num);
    vel_w    = NumW'(vel);
    vel_refl = div20(-((vel_w <<< 4) + vel_w));

    pos_pre = reflect ? PreSatW'(refl) : PreSatW'(sum);
    pos_nxt = sat_coord(pos_pre);
    vel_nxt = reflect ? CoordW'(vel_refl) : vel;
  end

endmodule

`default_nettype wire

@@ hdl/bounce_trajectory_stepper.sv @@
// ----------------------------------------------------------------------------
// bounce_trajectory_stepper
// Predicts the path of a point bouncing in a box, one point per transaction.
//
//   Channel  Ports                               Payload
//   input    in_valid / in_ready / in_data       bts_pkg::in_item_t
//   result   out_valid / out_ready / out_data    bts_pkg::out_item_t
//   config   cfg_valid / cfg_ready / cfg_index   cfg_data (16-bit wall)
//
// Every transaction passes through the input register and then one step of
// the position/velocity state, whose registers present the result. One
// transaction can be accepted per cycle while the result is not stalled.
// The rate is set by the state update loop. Reset is synchronous and clears
// the state to the origin at step 0. A stalled result holds the state, and
// the input register keeps accepting until it too is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bounce_trajectory_stepper (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bts_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output bts_pkg::out_item_t       out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import bts_pkg::*;

  bounds_t          bounds;
  logic             in_vld_r;
  in_item_t         in_data_r;
  logic             out_valid_r;
  coord_t           pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  coord_t           pos_x_nxt, pos_y_nxt, vel_x_nxt, vel_y_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  coord_t           adv_pos_x, adv_pos_y, adv_vel_x, adv_vel_y;
  logic signed [SumW-1:0] dx, dy;
  logic             adv;
  logic             load;

  bts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bounds    (bounds)
  );

  bts_axis_step u_axis_x (
    .pos     (pos_x_r),
    .vel     (vel_x_r),
    .lo      (bounds.min_x),
    .hi      (bounds.max_x),
    .lo37    (bounds.min_x37),
    .hi37    (bounds.max_x37),
    .pos_nxt (adv_pos_x),
    .vel_nxt (adv_vel_x)
  );

  bts_axis_step u_axis_y (
    .pos     (pos_y_r),
    .vel     (vel_y_r),
    .lo      (bounds.min_y),
    .hi      (bounds.max_y),
    .lo37    (bounds.min_y37),
    .hi37    (bounds.max_y37),
    .pos_nxt (adv_pos_y),
    .vel_nxt (adv_vel_y)
  );

  assign adv      = !out_valid_r || out_ready;
  assign load     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  // Truncating divide by 8: bias negative differences by 7 before the shift.
  function automatic coord_t vel_div8(input logic signed [SumW-1:0] d);
    logic signed [SumW-1:0] b;
    b = d + (d[SumW-1] ? SumW'(7) : SumW'(0));
    return CoordW'(b >>> 3);
  endfunction

  always_comb begin
    dx        = SumW'(in_data_r.now_x) - SumW'(in_data_r.past_x);
    dy        = SumW'(in_data_r.now_y) - SumW'(in_data_r.past_y);
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    vel_x_nxt = vel_x_r;
    vel_y_nxt = vel_y_r;
    step_nxt  = step_r;
    if (load) begin
      unique case (in_data_r.func)
        FuncStart: begin
          pos_x_nxt = in_data_r.now_x;
          pos_y_nxt = in_data_r.now_y;
          vel_x_nxt = vel_div8(dx);
          vel_y_nxt = vel_div8(dy);
          step_nxt  = '0;
        end
        FuncAdvance: begin
          // Past the last point the state freezes and the point repeats.
          if (step_r != LastStep) begin
            pos_x_nxt = adv_pos_x;
            pos_y_nxt = adv_pos_y;
            vel_x_nxt = adv_vel_x;
            vel_y_nxt = adv_vel_y;
            step_nxt  = step_r + 1'b1;
          end
        end
        default: step_nxt = step_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      step_r      <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_vld_r;
      end
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
      vel_x_r <= vel_x_nxt;
      vel_y_r <= vel_y_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // The state registers double as the result register.
  assign out_valid            = out_valid_r;
  assign out_data.point_x     = pos_x_r;
  assign out_data.point_y     = pos_y_r;
  assign out_data.step_number = step_r;
  assign out_data.final_point = (step_r == LastStep);

  step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LastStep)
    else $error("step counter beyond last point");
  held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_data_r))
    else $error("pending transaction lost while result stalled");
  start_clears_step: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_data_r.func == FuncStart |=> step_r == '0)
    else $error("start did not restart the step count");
  advance_counts: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_data_r.func == FuncAdvance && step_r != LastStep
      |=> step_r == $past(step_r) + 1'b1)
    else $error("advance did not count one step");
  state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(pos_x_r) && $stable(step_r))
    else $error("state moved under a stalled result");

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Bounce trajectory stepper testbench
// Drives start and advance transactions with random gaps and result stalls,
// writes the wall registers between phases, and checks every result against
// a scoreboard that tracks position, velocity and step index on its own.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int          LongRun    = 805;

  class bounce_scoreboard;
    coord_t           walls[4];
    coord_t           pos_x, pos_y, vel_x, vel_y;
    logic [StepW-1:0] step;
    out_item_t        pending[$];
    int               errors;

    function new();
      walls[RegMinX] = 16'sd0;
      walls[RegMinY] = 16'sd0;
      walls[RegMaxX] = 16'sd100;
      walls[RegMaxY] = 16'sd100;
      pos_x  = '0;
      pos_y  = '0;
      vel_x  = '0;
      vel_y  = '0;
      step   = '0;
      errors = 0;
    endfunction

    function void set_wall(cfg_reg_t idx, coord_t val);
      walls[idx] = val;
    endfunction

    // One axis of motion: move, bounce off the first wall crossed, clamp.
    function void move_axis(inout coord_t pos, inout coord_t vel,
                            input coord_t lo, input coord_t hi);
      int nxt;
      nxt = int'(pos) + int'(vel);
      if (nxt < int'(lo)) begin
        nxt = (37 * int'(lo) - 17 * nxt) / 20;
        vel = coord_t'((-17 * int'(vel)) / 20);
      end else if (nxt > int'(hi)) begin
        nxt = (37 * int'(hi) - 17 * nxt) / 20;
        vel = coord_t'((-17 * int'(vel)) / 20);
      end
      if (nxt > 32767) begin
        nxt = 32767;
      end else if (nxt < -32768) begin
        nxt = -32768;
      end
      pos = coord_t'(nxt);
    endfunction

    function void note_input(in_item_t it);
      out_item_t exp;
      if (it.func == FuncStart) begin
        vel_x = coord_t'((int'(it.now_x) - int'(it.past_x)) / 8);
        vel_y = coord_t'((int'(it.now_y) - int'(it.past_y)) / 8);
        pos_x = it.now_x;
        pos_y = it.now_y;
        step  = '0;
      end else if (step < LastStep) begin
        move_axis(pos_x, vel_x, walls[RegMinX], walls[RegMaxX]);
        move_axis(pos_y, vel_y, walls[RegMinY], walls[RegMaxY]);
        step++;
      end
      exp.point_x     = pos_x;
      exp.point_y     = pos_y;
      exp.step_number = step;
      exp.final_point = (step == LastStep);
      pending.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: point (%0d, %0d) step %0d",
               got.point_x, got.point_y, got.step_number);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.point_x !== exp.point_x) begin
        $error("point_x mismatch: expected %0d, got %0d", exp.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== exp.point_y) begin
        $error("point_y mismatch: expected %0d, got %0d", exp.point_y, got.point_y);
        errors++;
      end
      if (got.step_number !== exp.step_number) begin
        $error("step_number mismatch: expected %0d, got %0d",
               exp.step_number, got.step_number);
        errors++;
      end
      if (got.final_point !== exp.final_point) begin
        $error("final_point mismatch: expected %0b, got %0b",
               exp.final_point, got.final_point);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // Set during one phase to run both sides without any idle cycles.
  bit          calm = 1'b0;
  int unsigned cycle_count = 0;
  coord_t      walls[4];

  bounce_scoreboard sb = new();

  bounce_trajectory_stepper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_wall(cfg_reg_t'(cfg_index), coord_t'(cfg_data));
      end
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 31);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Called right after a rising edge; returns at the edge that takes the item.
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_start(coord_t px, coord_t py, coord_t nx, coord_t ny);
    in_item_t it;
    it.func   = FuncStart;
    it.past_x = px;
    it.past_y = py;
    it.now_x  = nx;
    it.now_y  = ny;
    send_item(it);
  endtask

  // Advance transactions carry random coordinates, which the block ignores.
  task automatic send_advances(int count);
    in_item_t it;
    repeat (count) begin
      it.func   = FuncAdvance;
      it.past_x = coord_t'($urandom);
      it.past_y = coord_t'($urandom);
      it.now_x  = coord_t'($urandom);
      it.now_y  = coord_t'($urandom);
      send_item(it);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_wall(cfg_reg_t idx, coord_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    walls[idx] = val;
  endtask

  task automatic write_box(coord_t lo_x, coord_t lo_y, coord_t hi_x, coord_t hi_y);
    write_wall(RegMinX, lo_x);
    write_wall(RegMinY, lo_y);
    write_wall(RegMaxX, hi_x);
    write_wall(RegMaxY, hi_y);
  endtask

  // Places the current point between the walls and picks a past point no more
  // than 4 * span + 64 (capped at 65535) away on either side, clamped to 16 bits.
  function automatic void aim_axis(input coord_t a, input coord_t b,
                                   output coord_t past, output coord_t now);
    int lo, hi, span, now_i, reach, past_i;
    lo     = (a < b) ? int'(a) : int'(b);
    hi     = (a < b) ? int'(b) : int'(a);
    span   = hi - lo;
    now_i  = lo + int'($urandom_range(span));
    reach  = 4 * span + 64;
    if (reach > 65535) begin
      reach = 65535;
    end
    past_i = now_i - (int'($urandom_range(2 * reach)) - reach);
    if (past_i > 32767) begin
      past_i = 32767;
    end else if (past_i < -32768) begin
      past_i = -32768;
    end
    past = coord_t'(past_i);
    now  = coord_t'(now_i);
  endfunction

  task automatic run_trajectories(int budget, bit long_run);
    int       sent;
    int       len;
    coord_t   px, py, nx, ny;
    in_item_t it;
    sent = 0;
    while (sent < budget) begin
      if (!long_run && $urandom_range(9) == 0) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          it.func   = func_t'($urandom_range(1));
          it.past_x = coord_t'($urandom);
          it.past_y = coord_t'($urandom);
          it.now_x  = coord_t'($urandom);
          it.now_y  = coord_t'($urandom);
          send_item(it);
        end
        sent += len;
      end else begin
        if ($urandom_range(9) < 3) begin
          px = coord_t'($urandom);
          py = coord_t'($urandom);
          nx = coord_t'($urandom);
          ny = coord_t'($urandom);
        end else begin
          aim_axis(walls[RegMinX], walls[RegMaxX], px, nx);
          aim_axis(walls[RegMinY], walls[RegMaxY], py, ny);
        end
        send_start(px, py, nx, ny);
        // A long run goes past the last step so the final point repeats.
        len = long_run ? LongRun : $urandom_range(0, 40);
        long_run = 1'b0;
        send_advances(len);
        sent += len + 1;
      end
      if ($urandom_range(24) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    int lo;
    walls[RegMinX] = 16'sd0;
    walls[RegMinY] = 16'sd0;
    walls[RegMaxX] = 16'sd100;
    walls[RegMaxY] = 16'sd100;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset walls. Advancing before any start moves
    // from the origin with zero velocity.
    send_advances(2);
    send_start(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
    send_advances(3);
    send_start(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_advances(2);
    // Velocity of -15/8 and 15/8 truncates toward zero.
    send_start(16'sd0, 16'sd0, -16'sd15, 16'sd15);
    send_advances(1);
    send_start(16'sd10, 16'sd90, 16'sd90, 16'sd10);
    send_advances(8);
    send_start(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    send_advances(2);
    wait_drained();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_box(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        end
        1: begin
          // Inverted box on x and a zero-width box on y.
          write_box(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
        end
        4: begin
          write_box(coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom));
        end
        default: begin
          lo = $urandom_range(4000) - 2000;
          write_box(coord_t'(lo), coord_t'(lo - 300),
                    coord_t'(lo + $urandom_range(1, 400)),
                    coord_t'(lo + $urandom_range(0, 200)));
        end
      endcase
      calm = (phase == 3);
      run_trajectories((phase == 1) ? 880 : 170, phase == 1);
      wait_drained();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
